// ===== rtl/zrle_pkg.sv =====
// ----------------------------------------------------------------------------
// Zero-run RLE decoder package
// Shared constants for the decoder: field widths, phase codes and register
// indexes of the configuration port.
// ----------------------------------------------------------------------------
package zrle_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 16;
	localparam int PHASE_W = 2;

	localparam logic [PHASE_W-1:0] PHASE_LITERAL    = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_COUNT_LOW  = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_COUNT_HIGH = 2'd2;

	localparam logic REG_START = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

endpackage

// ===== rtl/zrle_cfg.sv =====
// ----------------------------------------------------------------------------
// Zero-run RLE decoder configuration registers
// APB-style register file holding the start and limit addresses. A write of
// the start address raises a one-cycle restart pulse for the decoder core.
// ----------------------------------------------------------------------------
module zrle_cfg
	import zrle_pkg::*;
#(
	parameter int ADDR_BITS = 20,
	parameter int DATA_W    = 32,
	parameter int PADDR_W   = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic [ADDR_BITS-1:0] start_address,
	output logic [ADDR_BITS:0]   limit_address,
	output logic                 restart
);

	logic                 wr_en;
	logic                 reg_idx;
	logic [ADDR_BITS-1:0] start_q;
	logic [ADDR_BITS:0]   limit_q;
	logic                 restart_q;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[PADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			limit_q   <= {1'b1, {ADDR_BITS{1'b0}}};
			restart_q <= 1'b0;
		end else begin
			restart_q <= 1'b0;
			if (wr_en) begin
				unique case (reg_idx)
					REG_START: begin
						start_q   <= pwdata[ADDR_BITS-1:0];
						restart_q <= 1'b1;
					end
					REG_LIMIT: begin
						limit_q <= pwdata[ADDR_BITS:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_START: prdata[ADDR_BITS-1:0] = start_q;
			REG_LIMIT: prdata[ADDR_BITS:0]   = limit_q;
			default:   prdata = '0;
		endcase
	end

	assign start_address = start_q;
	assign limit_address = limit_q;
	assign restart       = restart_q;

endmodule

// ===== rtl/zrle_core.sv =====
// ----------------------------------------------------------------------------
// Zero-run RLE decoder core
// Input register, decode state and result register. Literal bytes become
// writes at the pointer; two zeros start a 16-bit little-endian skip count.
// ----------------------------------------------------------------------------
module zrle_core
	import zrle_pkg::*;
#(
	parameter int ADDR_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [ADDR_BITS-1:0] start_address,
	input  logic [ADDR_BITS:0]   limit_address,
	input  logic                 restart,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    byte_value,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ADDR_BITS-1:0] write_address,
	output logic [BYTE_W-1:0]    write_data,
	output logic                 overflow
);

	localparam int PTR_W = ADDR_BITS + 1;
	localparam int SUM_W = ((PTR_W > COUNT_W) ? PTR_W : COUNT_W) + 1;

	logic                 valid_s1;
	logic [BYTE_W-1:0]    byte_s1;
	logic                 last_s1;

	logic [PTR_W-1:0]     ptr_q;
	logic                 zero_seen_q;
	logic [PHASE_W-1:0]   phase_q;
	logic [BYTE_W-1:0]    count_low_q;

	logic                 out_valid_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [BYTE_W-1:0]    data_q;
	logic                 ovf_q;

	logic                 out_free;
	logic                 is_literal;
	logic                 fire_s1;
	logic [PTR_W-1:0]     eff_limit;
	logic                 at_limit;
	logic [SUM_W-1:0]     skip_sum;
	logic [SUM_W-1:0]     limit_ext;
	logic [PTR_W-1:0]     ptr_skip;
	logic [PTR_W-1:0]     ptr_d;
	logic                 zero_seen_d;
	logic [PHASE_W-1:0]   phase_d;
	logic [BYTE_W-1:0]    count_low_d;

	assign out_free   = !out_valid_q || out_ready;
	assign is_literal = (phase_q != PHASE_COUNT_LOW) && (phase_q != PHASE_COUNT_HIGH);
	assign fire_s1    = valid_s1 && (!is_literal || out_free);
	assign in_ready   = !valid_s1 || fire_s1;

	assign eff_limit = limit_address[ADDR_BITS] ? {1'b1, {ADDR_BITS{1'b0}}} : limit_address;
	assign at_limit  = (ptr_q >= eff_limit);
	assign skip_sum  = SUM_W'(ptr_q) + SUM_W'({byte_s1, count_low_q});
	assign limit_ext = SUM_W'(eff_limit);
	assign ptr_skip  = (skip_sum > limit_ext) ? eff_limit : skip_sum[PTR_W-1:0];

	always_comb begin
		ptr_d       = ptr_q;
		zero_seen_d = zero_seen_q;
		phase_d     = phase_q;
		count_low_d = count_low_q;
		unique case (phase_q)
			PHASE_COUNT_LOW: begin
				count_low_d = byte_s1;
				phase_d     = PHASE_COUNT_HIGH;
			end
			PHASE_COUNT_HIGH: begin
				ptr_d       = ptr_skip;
				phase_d     = PHASE_LITERAL;
				zero_seen_d = 1'b0;
				count_low_d = '0;
			end
			default: begin
				if (!at_limit) begin
					ptr_d = ptr_q + PTR_W'(1);
				end
				phase_d = PHASE_LITERAL;
				if (byte_s1 != '0) begin
					zero_seen_d = 1'b0;
				end else if (zero_seen_q) begin
					zero_seen_d = 1'b0;
					phase_d     = PHASE_COUNT_LOW;
				end else begin
					zero_seen_d = 1'b1;
				end
			end
		endcase
		if (last_s1) begin
			ptr_d       = PTR_W'(start_address);
			zero_seen_d = 1'b0;
			phase_d     = PHASE_LITERAL;
			count_low_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			ptr_q       <= '0;
			zero_seen_q <= 1'b0;
			phase_q     <= PHASE_LITERAL;
			count_low_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (restart) begin
				ptr_q       <= PTR_W'(start_address);
				zero_seen_q <= 1'b0;
				phase_q     <= PHASE_LITERAL;
				count_low_q <= '0;
			end else if (fire_s1) begin
				ptr_q       <= ptr_d;
				zero_seen_q <= zero_seen_d;
				phase_q     <= phase_d;
				count_low_q <= count_low_d;
			end
			if (fire_s1 && is_literal) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_value;
			last_s1 <= last_byte;
		end
		if (fire_s1 && is_literal) begin
			addr_q <= at_limit ? '0 : ptr_q[ADDR_BITS-1:0];
			data_q <= at_limit ? '0 : byte_s1;
			ovf_q  <= at_limit;
		end
	end

	assign out_valid     = out_valid_q;
	assign write_address = addr_q;
	assign write_data    = data_q;
	assign overflow      = ovf_q;

endmodule

// ===== rtl/zero_run_rle_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Zero-run RLE decoder top level
// Decodes a zero-run-length byte stream into byte writes for a zero-filled
// destination region, with an APB-style port for start and limit addresses.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    byte_value, last_byte
//   output    out_valid / out_ready  write_address, write_data, overflow
//   config    psel / penable         paddr, pwrite, pwdata, prdata, pready
//
// One byte is accepted per cycle while the output side has room; a literal byte's
// write is offered through the input register and then the result register.
// Count bytes give no write and never wait for the output side.
// A stalled output holds one result and one byte in the input register.
// Reset clears the pipeline, sets the pointer to the start address and the
// limit to the top of the address space. Writing the start address restarts.
// ----------------------------------------------------------------------------
module zero_run_rle_decoder_top
	import zrle_pkg::*;
#(
	parameter int ADDR_BITS = 20,
	localparam int DATA_W  = (ADDR_BITS + 1 > 32) ? 64 : 32,
	localparam int PADDR_W = (DATA_W == 64) ? 4 : 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    byte_value,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ADDR_BITS-1:0] write_address,
	output logic [BYTE_W-1:0]    write_data,
	output logic                 overflow
);

	logic [ADDR_BITS-1:0] start_address;
	logic [ADDR_BITS:0]   limit_address;
	logic                 restart;

	assign pready = 1'b1;

	zrle_cfg #(
		.ADDR_BITS(ADDR_BITS),
		.DATA_W   (DATA_W),
		.PADDR_W  (PADDR_W)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.start_address(start_address),
		.limit_address(limit_address),
		.restart      (restart)
	);

	zrle_core #(
		.ADDR_BITS(ADDR_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_address(start_address),
		.limit_address(limit_address),
		.restart      (restart),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_value   (byte_value),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_address(write_address),
		.write_data   (write_data),
		.overflow     (overflow)
	);

endmodule

// ===== rtl/zrle_checker.sv =====
// ----------------------------------------------------------------------------
// Zero-run RLE decoder port checker
// Checks the output channel and the coupling of the two channels as seen at
// the top-level ports.
// ----------------------------------------------------------------------------
module zrle_checker
	import zrle_pkg::*;
#(
	parameter int ADDR_BITS = 20
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [ADDR_BITS-1:0] write_address,
	input logic [BYTE_W-1:0]    write_data,
	input logic                 overflow
);

	// A stalled result item keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(write_address)
			&& $stable(write_data) && $stable(overflow))
		else $error("result item changed while stalled");

	// A suppressed write carries zero address and data.
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> write_address == '0 && write_data == '0)
		else $error("suppressed write carries nonzero payload");

	// With no result pending, the input side never stalls.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output is empty");

endmodule

bind zero_run_rle_decoder_top zrle_checker #(.ADDR_BITS(ADDR_BITS)) u_zrle_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.write_address(write_address),
	.write_data   (write_data),
	.overflow     (overflow)
);

// ===== bench/zrle_write_checker.sv =====
// ----------------------------------------------------------------------------
// Zero-run RLE decoder write checker
// Watches the configuration port and both channels of the decoder. It keeps its
// own copy of the start and limit addresses, the write pointer and the zero
// tracking state, works out the write that each accepted byte should cause,
// and compares every accepted write field by field with the oldest one due.
// ----------------------------------------------------------------------------
module zrle_write_checker
	import zrle_pkg::*;
#(
	parameter int ADDR_BITS = 20,
	parameter int DATA_W    = 32,
	parameter int PADDR_W   = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]    pwdata,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [BYTE_W-1:0]    byte_value,
	input  logic                 last_byte,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [ADDR_BITS-1:0] write_address,
	input  logic [BYTE_W-1:0]    write_data,
	input  logic                 overflow,
	output int                   fail_count,
	output int                   pending
);

	localparam int REG_BYTES = DATA_W / 8;
	localparam logic [ADDR_BITS:0] ADDR_SPAN = {1'b1, {ADDR_BITS{1'b0}}};

	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		logic [BYTE_W-1:0]    data;
		logic                 ovf;
	} byte_write_t;

	byte_write_t expected_writes[$];

	logic [ADDR_BITS-1:0] start_q;
	logic [ADDR_BITS:0]   limit_q;
	logic [ADDR_BITS:0]   ptr_q;
	logic                 zero_seen_q;
	logic [PHASE_W-1:0]   phase_q;
	logic [BYTE_W-1:0]    count_lo_q;

	task automatic report_mismatch(input string msg);
		$display("%0t: write mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic restart_stream();
		ptr_q       = {1'b0, start_q};
		zero_seen_q = 1'b0;
		phase_q     = PHASE_LITERAL;
		count_lo_q  = '0;
	endtask

	task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic lst);
		logic [ADDR_BITS:0]         lim;
		logic [ADDR_BITS+COUNT_W:0] jump;
		byte_write_t                w;
		lim = (limit_q > ADDR_SPAN) ? ADDR_SPAN : limit_q;
		case (phase_q)
			PHASE_COUNT_LOW: begin
				count_lo_q = b;
				phase_q    = PHASE_COUNT_HIGH;
			end
			PHASE_COUNT_HIGH: begin
				jump        = ptr_q + {b, count_lo_q};
				ptr_q       = (jump > lim) ? lim : jump[ADDR_BITS:0];
				phase_q     = PHASE_LITERAL;
				zero_seen_q = 1'b0;
				count_lo_q  = '0;
			end
			default: begin
				if (ptr_q >= lim) begin
					w.addr = '0;
					w.data = '0;
					w.ovf  = 1'b1;
				end else begin
					w.addr = ptr_q[ADDR_BITS-1:0];
					w.data = b;
					w.ovf  = 1'b0;
					ptr_q  = ptr_q + 1'b1;
				end
				expected_writes.push_back(w);
				phase_q = PHASE_LITERAL;
				if (b != '0) begin
					zero_seen_q = 1'b0;
				end else if (zero_seen_q) begin
					zero_seen_q = 1'b0;
					phase_q     = PHASE_COUNT_LOW;
				end else begin
					zero_seen_q = 1'b1;
				end
			end
		endcase
		if (lst)
			restart_stream();
	endtask

	always @(posedge clk or negedge arst_n) begin
		byte_write_t w;
		if (!arst_n) begin
			start_q = '0;
			limit_q = ADDR_SPAN;
			restart_stream();
			expected_writes.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_writes.size() == 0) begin
					report_mismatch($sformatf("unexpected write addr %h data %h ovf %b",
						write_address, write_data, overflow));
				end else begin
					w = expected_writes.pop_front();
					if (write_address !== w.addr)
						report_mismatch($sformatf("write_address %h, expected %h",
							write_address, w.addr));
					if (write_data !== w.data)
						report_mismatch($sformatf("write_data %h, expected %h",
							write_data, w.data));
					if (overflow !== w.ovf)
						report_mismatch($sformatf("overflow %b, expected %b",
							overflow, w.ovf));
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (int'(paddr) == int'(REG_START) * REG_BYTES) begin
					start_q = pwdata[ADDR_BITS-1:0];
					restart_stream();
				end else if (int'(paddr) == int'(REG_LIMIT) * REG_BYTES) begin
					limit_q = pwdata[ADDR_BITS:0];
				end
			end
			if (in_valid && in_ready)
				decode_byte(byte_value, last_byte);
			pending = expected_writes.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Zero-run RLE decoder testbench
// Drives compressed bytes and register writes into the decoder, with random
// gaps on the byte input and random back-pressure on the write output. A short
// directed stream covers literals, skips, overflow and restarts; random
// streams under changing start and limit addresses follow. The write checker
// beside the decoder predicts and compares every write.
// ----------------------------------------------------------------------------
module tb_top;
	import zrle_pkg::*;

	localparam int ADDR_BITS   = 20;
	localparam int DATA_W      = (ADDR_BITS + 1 > 32) ? 64 : 32;
	localparam int PADDR_W     = (DATA_W == 64) ? 4 : 3;
	localparam int REG_BYTES   = DATA_W / 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_ITEMS = 115;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 psel       = 1'b0;
	logic                 penable    = 1'b0;
	logic                 pwrite     = 1'b0;
	logic [PADDR_W-1:0]   paddr      = '0;
	logic [DATA_W-1:0]    pwdata     = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    byte_value = '0;
	logic                 last_byte  = 1'b0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [ADDR_BITS-1:0] write_address;
	logic [BYTE_W-1:0]    write_data;
	logic                 overflow;

	int cycles    = 0;
	bit tx_quiet  = 1'b0;
	bit rx_quiet  = 1'b0;
	bit want_hold = 1'b0;
	bit hold_done = 1'b0;
	int fail_count;
	int pending;

	zero_run_rle_decoder_top #(.ADDR_BITS(ADDR_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.byte_value(byte_value), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.write_address(write_address), .write_data(write_data), .overflow(overflow)
	);

	zrle_write_checker #(.ADDR_BITS(ADDR_BITS), .DATA_W(DATA_W), .PADDR_W(PADDR_W)) write_chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.byte_value(byte_value), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.write_address(write_address), .write_data(write_data), .overflow(overflow),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// The receiver runs on falling edges; it takes one long hold-off on request.
	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (want_hold && !hold_done) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			gap = pick_gap(rx_quiet);
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			repeat ($urandom_range(0, 11)) @(negedge clk);
		end
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic lst);
		int gap;
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		byte_value = b;
		last_byte  = lst;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic push_skip(input logic [COUNT_W-1:0] count);
		push_byte(8'h00, chance(2));
		push_byte(8'h00, chance(2));
		push_byte(count[7:0], chance(3));
		push_byte(count[15:8], chance(3));
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic reg_write(input int idx, input logic [DATA_W-1:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = PADDR_W'(idx * REG_BYTES);
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic random_config(input int mode);
		logic [DATA_W-1:0] s;
		logic [DATA_W-1:0] lim;
		case ($urandom_range(0, 3))
			0: s = '0;
			1: s = '1;
			2: s = DATA_W'($urandom_range(0, 1000));
			default: s = DATA_W'($urandom);
		endcase
		case (mode == 0 ? 0 : mode == 1 ? 2 : $urandom_range(0, 4))
			0: lim = '1;
			1: lim = DATA_W'(1) << ADDR_BITS;
			2: lim = '0;
			3: lim = DATA_W'(s[ADDR_BITS-1:0]) + DATA_W'($urandom_range(0, 300));
			default: lim = DATA_W'($urandom);
		endcase
		if (mode == 1)
			s = '0;
		if (chance(50)) begin
			reg_write(REG_START, s);
			reg_write(REG_LIMIT, lim);
		end else begin
			reg_write(REG_LIMIT, lim);
			reg_write(REG_START, s);
		end
	endtask

	task automatic random_stream(input int n_items);
		int sent;
		int r;
		logic [COUNT_W-1:0] count;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				push_byte(8'($urandom_range(1, 255)), chance(2));
				sent += 1;
			end else if (r < 62) begin
				push_byte(8'h00, chance(2));
				push_byte(8'($urandom_range(1, 255)), chance(2));
				sent += 2;
			end else if (r < 88) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					count = COUNT_W'($urandom_range(0, 40));
				else if (r < 85)
					count = COUNT_W'($urandom);
				else
					count = chance(50) ? '0 : '1;
				push_skip(count);
				sent += 4;
			end else begin
				push_byte(8'($urandom), chance(5));
				sent += 1;
			end
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Default registers: literals, a mid-range and the largest skip, last byte inside a count.
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_skip(16'h1234);
		push_byte(8'h01, 1'b0);
		push_skip(16'hFFFF);
		push_byte(8'h55, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h05, 1'b1);
		push_byte(8'hAA, 1'b1);

		// Top of the address space: writes run into the limit and overflow.
		wait_idle();
		reg_write(REG_START, '1);
		push_byte(8'h11, 1'b0);
		push_byte(8'h22, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h10, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h33, 1'b1);

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			random_config(p);
			tx_quiet = chance(25);
			rx_quiet = chance(25);
			if (p == 2) begin
				tx_quiet  = 1'b1;
				want_hold = 1'b1;
			end
			random_stream(PHASE_ITEMS);
		end

		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
